[rtl/wav_header_parser_macros.svh]
// Assertion macros used by the WAV header parser top level.
`ifndef WAV_HEADER_PARSER_MACROS_SVH
`define WAV_HEADER_PARSER_MACROS_SVH

`ifndef SYNTH

`define WAVHP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`define WAVHP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define WAVHP_ASSERT_NEVER(label, cond, msg)

`define WAVHP_ASSERT_IMPLIES(label, ante, cons, msg)

`endif

`endif

[rtl/wavhp_pkg.sv]
// Types, codes and constants shared by the WAV header parser modules.
`default_nettype none

package wavhp_pkg;

    localparam logic [5:0] RIFF_LAST_IDX = 6'd3;
    localparam logic [5:0] HDR_LAST_IDX  = 6'd43;
    localparam logic [15:0] MONO_CHANNELS = 16'd1;
    localparam logic [15:0] PCM_FORMAT    = 16'd1;
    localparam logic [15:0] BITS_NARROW   = 16'd8;
    localparam logic [15:0] BITS_WIDE     = 16'd16;

    localparam logic [31:0] MAGIC_WORDS [4] = '{
        32'h4646_4952, 32'h4556_4157, 32'h2074_6D66, 32'h6174_6164
    };

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } wavhp_kind_t;

    typedef enum logic [2:0] {
        ERR_RIFF     = 3'd0,
        ERR_WAVE     = 3'd1,
        ERR_FMT      = 3'd2,
        ERR_DATA     = 3'd3,
        ERR_CHANNELS = 3'd4,
        ERR_BITS     = 3'd5,
        ERR_FORMAT   = 3'd6
    } wavhp_err_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_SAMPLES = 4'b0100,
        PH_STOP    = 4'b1000
    } wavhp_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } wavhp_byte_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample_value;
        logic [31:0]        rate_hz;
        logic [31:0]        sample_count;
        logic               wide_samples;
        logic [2:0]         error_code;
        logic               last;
    } wavhp_result_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] sel;
    } wavhp_magic_slot_t;

    // Which magic word, if any, covers a given header byte position.
    function automatic wavhp_magic_slot_t magic_slot(input logic [5:0] idx);
        wavhp_magic_slot_t s;
        case (idx) inside
            [6'd0:6'd3]:   s = '{hit: 1'b1, sel: 2'd0};
            [6'd8:6'd11]:  s = '{hit: 1'b1, sel: 2'd1};
            [6'd12:6'd15]: s = '{hit: 1'b1, sel: 2'd2};
            [6'd36:6'd39]: s = '{hit: 1'b1, sel: 2'd3};
            default:       s = '{hit: 1'b0, sel: 2'd0};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/wav_header_parser.sv]
// Mono PCM WAV stream parser: top level with input, parse and result stages.
//
// Bytes enter on the byte channel (byte_valid, byte_stall, byte_data); a byte
// whose start_req is set begins a new file and abandons any file in progress.
// Results leave on the result channel (result_valid, result_stall, result):
// one error, one header, or one sample per transfer.
// A byte is registered, then parsed against the stored header state, and any
// result it produces is registered for output, so a result is presented only
// from the result register, after its byte has passed the input register. One
// byte is taken every cycle while the receiver keeps up; the single parse
// stage sets that rate.
// Header fields are read from the fixed 44-byte layout; the RIFF magic is
// checked after the fourth byte and the remaining checks after the last one.
// Bytes before a start, after an error or after the final sample are dropped.
// Reset returns the parser to idle, waiting for a start byte, with both
// stages empty. When the receiver stalls, the result stays held and one more
// byte is kept in the input register, after which byte_stall is raised.
`default_nettype none
`include "wav_header_parser_macros.svh"

module wav_header_parser
    import wavhp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    output logic               byte_stall,
    input  wire wavhp_byte_t   byte_data,
    output logic               result_valid,
    input  wire logic          result_stall,
    output wavhp_result_t      result
);

    logic          load_ok;
    logic          item_valid;
    wavhp_byte_t   item;
    logic          res_valid;
    wavhp_result_t res;

    wavhp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .load_ok    (load_ok),
        .item_valid (item_valid),
        .item       (item)
    );

    wavhp_parse_core u_parse_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .load_ok    (load_ok),
        .res_valid  (res_valid),
        .res        (res)
    );

    wavhp_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .load_ok      (load_ok),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `WAVHP_ASSERT_IMPLIES(a_stall_only_when_blocked, byte_stall, item_valid && result_valid && result_stall, "Input stalled while the result stage could load.")
    `WAVHP_ASSERT_IMPLIES(a_error_fields_clear, result_valid && (result.kind == KIND_ERROR), !result.last && !result.wide_samples && (result.sample_count == 32'd0), "Error result carries header or sample fields.")
    `WAVHP_ASSERT_IMPLIES(a_empty_header_last, result_valid && (result.kind == KIND_HEADER) && (result.sample_count == 32'd0), result.last, "Header with no samples is not marked last.")
    `WAVHP_ASSERT_NEVER(a_kind_defined, result_valid && (result.kind != KIND_HEADER) && (result.kind != KIND_SAMPLE) && (result.kind != KIND_ERROR), "Result transfer with an undefined kind.")

endmodule

`default_nettype wire

[rtl/wavhp_in_stage.sv]
// Input register that holds one byte transfer for the parse stage.
`default_nettype none

module wavhp_in_stage
    import wavhp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire wavhp_byte_t byte_data,
    input  wire logic        load_ok,
    output logic             item_valid,
    output wavhp_byte_t      item
);

    logic        valid_reg;
    logic        valid_next;
    wavhp_byte_t item_reg;
    logic        take;

    assign byte_stall = valid_reg && !load_ok;
    assign take       = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (load_ok)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= byte_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[rtl/wavhp_parse_core.sv]
// Parse state and the per-byte header, check and sample logic.
`default_nettype none

module wavhp_parse_core
    import wavhp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire wavhp_byte_t item,
    input  wire logic        load_ok,
    output logic             res_valid,
    output wavhp_result_t    res
);

    wavhp_phase_t phase_reg, phase_next;
    logic [5:0]   idx_reg, idx_next;
    logic [3:0]   flags_reg, flags_next;
    logic [15:0]  chan_reg, chan_next;
    logic [15:0]  fmt_reg, fmt_next;
    logic [15:0]  bits_reg, bits_next;
    logic [31:0]  rate_reg, rate_next;
    logic [31:0]  size_reg, size_next;
    logic [31:0]  left_reg, left_next;
    logic [7:0]   low_reg, low_next;
    logic         odd_reg, odd_next;

    wavhp_phase_t      phase_eff;
    logic [5:0]        idx_eff;
    logic [3:0]        flags_eff;
    wavhp_magic_slot_t slot;
    logic [7:0]        want;
    logic [7:0]        b;
    logic              wide;
    logic [31:0]       count;
    logic              hit;
    wavhp_result_t     r;

    always_comb
    begin
        b          = item.data_byte;
        phase_eff  = item.start_req ? PH_HEADER : phase_reg;
        idx_eff    = item.start_req ? 6'd0 : idx_reg;
        flags_eff  = item.start_req ? 4'hF : flags_reg;
        phase_next = phase_eff;
        idx_next   = idx_eff;
        flags_next = flags_eff;
        chan_next  = chan_reg;
        fmt_next   = fmt_reg;
        bits_next  = bits_reg;
        rate_next  = rate_reg;
        size_next  = size_reg;
        left_next  = left_reg;
        low_next   = low_reg;
        odd_next   = odd_reg;
        hit        = 1'b0;
        r          = '0;
        slot       = magic_slot(idx_eff);
        want       = MAGIC_WORDS[slot.sel][{idx_eff[1:0], 3'b000} +: 8];
        wide       = (bits_reg == BITS_WIDE);
        count      = '0;

        case (phase_eff)
            PH_HEADER:
            begin
                if (slot.hit && (b != want))
                begin
                    flags_next[slot.sel] = 1'b0;
                end
                case (idx_eff) inside
                    [6'd20:6'd21]: fmt_next[{idx_eff[0], 3'b000} +: 8] = b;
                    [6'd22:6'd23]: chan_next[{idx_eff[0], 3'b000} +: 8] = b;
                    [6'd24:6'd27]: rate_next[{idx_eff[1:0], 3'b000} +: 8] = b;
                    [6'd34:6'd35]: bits_next[{idx_eff[0], 3'b000} +: 8] = b;
                    [6'd40:6'd43]: size_next[{idx_eff[1:0], 3'b000} +: 8] = b;
                    default:       ;
                endcase

                if ((idx_eff == RIFF_LAST_IDX) && !flags_next[0])
                begin
                    hit          = 1'b1;
                    r.kind       = KIND_ERROR;
                    r.error_code = ERR_RIFF;
                    phase_next   = PH_STOP;
                end
                else if (idx_eff != HDR_LAST_IDX)
                begin
                    idx_next = 6'(idx_eff + 6'd1);
                end
                else
                begin
                    hit    = 1'b1;
                    r.kind = KIND_ERROR;
                    phase_next = PH_STOP;
                    if (!flags_next[1])
                    begin
                        r.error_code = ERR_WAVE;
                    end
                    else if (!flags_next[2])
                    begin
                        r.error_code = ERR_FMT;
                    end
                    else if (!flags_next[3])
                    begin
                        r.error_code = ERR_DATA;
                    end
                    else if (chan_reg != MONO_CHANNELS)
                    begin
                        r.error_code = ERR_CHANNELS;
                    end
                    else if ((bits_reg != BITS_NARROW) && (bits_reg != BITS_WIDE))
                    begin
                        r.error_code = ERR_BITS;
                    end
                    else if (fmt_reg != PCM_FORMAT)
                    begin
                        r.error_code = ERR_FORMAT;
                    end
                    else
                    begin
                        count          = wide ? {1'b0, size_next[31:1]} : size_next;
                        r.kind         = KIND_HEADER;
                        r.rate_hz      = rate_reg;
                        r.sample_count = count;
                        r.wide_samples = wide;
                        r.last         = (count == 32'd0);
                        left_next      = count;
                        odd_next       = 1'b0;
                        phase_next     = (count == 32'd0) ? PH_STOP : PH_SAMPLES;
                    end
                end
            end
            PH_SAMPLES:
            begin
                if (wide && !odd_reg)
                begin
                    low_next = b;
                    odd_next = 1'b1;
                end
                else
                begin
                    hit            = 1'b1;
                    odd_next       = 1'b0;
                    r.kind         = KIND_SAMPLE;
                    r.sample_value = wide ? {b, low_reg} : {{8{b[7]}}, b};
                    r.wide_samples = wide;
                    r.last         = (left_reg == 32'd1);
                    left_next      = 32'(left_reg - 32'd1);
                    if (left_reg == 32'd1)
                    begin
                        phase_next = PH_STOP;
                    end
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            flags_reg <= '0;
        end
        else if (item_valid && load_ok)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && load_ok)
        begin
            chan_reg <= chan_next;
            fmt_reg  <= fmt_next;
            bits_reg <= bits_next;
            rate_reg <= rate_next;
            size_reg <= size_next;
            left_reg <= left_next;
            low_reg  <= low_next;
            odd_reg  <= odd_next;
        end
    end

    assign res_valid = item_valid && hit;
    assign res       = r;

endmodule

`default_nettype wire

[rtl/wavhp_out_stage.sv]
// Result register that holds one result until the receiver takes it.
`default_nettype none

module wavhp_out_stage
    import wavhp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          res_valid,
    input  wire wavhp_result_t res,
    output logic               load_ok,
    output logic               result_valid,
    input  wire logic          result_stall,
    output wavhp_result_t      result
);

    logic          valid_reg;
    wavhp_result_t result_reg;

    assign load_ok = !valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
